// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker module of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle implication failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle implication failed");

`endif

// ===== rtl/cts_pkg.sv =====
// Types and constants shared by the countdown task scheduler files.
package cts_pkg;

    // Widths of the transaction fields.
    localparam int ID_W    = 8;
    localparam int CNT_W   = 8;
    localparam int SLOT_W  = 5;

    // One table entry as it is stored in the slot memory.
    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [CNT_W-1:0] period;
        logic [CNT_W-1:0] count;
    } t_slot;

endpackage

// ===== rtl/cts_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module cts_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                       i_wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                       o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/countdown_task_scheduler.sv =====
// Countdown task scheduler: slot table in RAM walked by a small sequencer.
//
// Usage. An input transaction is taken at a rising edge where start is high
// and busy is low. i_command low adds a task (id and reload period) to the
// first empty slot; when the table is full the last slot is overwritten and
// o_replaced_last is set. i_command high schedules: every filled slot counts
// down pass after pass and the first slot to reach zero is reloaded and
// reported on o_chosen_slot and o_chosen_task_id. An empty table reports
// o_no_task.
// Each result is shown for one cycle with o_done high; the receiver cannot
// stall it. An add or a schedule on an empty table returns its result in the
// cycle after acceptance and busy never rises. A schedule holds busy while
// one pass reads each slot to find the earliest expiry and a second pass
// rewrites each countdown; both go through the single read port of the slot
// memory, one slot a cycle.
// Reset empties the table; the slot memory itself is not cleared.
module countdown_task_scheduler #(
    parameter int SLOT_COUNT = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      i_command,
    input  logic [cts_pkg::ID_W-1:0]  i_new_task_id,
    input  logic [cts_pkg::CNT_W-1:0] i_reload_period,
    output logic                      o_done,
    output logic [cts_pkg::SLOT_W-1:0] o_chosen_slot,
    output logic [cts_pkg::ID_W-1:0]  o_chosen_task_id,
    output logic                      o_no_task,
    output logic                      o_replaced_last
);

    localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CW = $clog2(SLOT_COUNT + 1);
    localparam int SW = $bits(cts_pkg::t_slot);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_UPDATE
    } t_state;

    t_state                    r_state, n_state;
    logic [CW-1:0]             r_filled, n_filled;
    logic [CW-1:0]             r_issue, n_issue;
    logic                      r_pend, n_pend;
    logic [IW-1:0]             r_pend_idx, n_pend_idx;
    logic [cts_pkg::CNT_W-1:0] r_min, n_min;
    logic [IW-1:0]             r_win, n_win;
    logic [cts_pkg::ID_W-1:0]  r_win_id, n_win_id;
    logic                      r_done, n_done;
    logic [cts_pkg::SLOT_W-1:0] r_slot, n_slot;
    logic [cts_pkg::ID_W-1:0]  r_id, n_id;
    logic                      r_no_task, n_no_task;
    logic                      r_replaced, n_replaced;

    logic                      ram_we;
    logic [IW-1:0]             ram_waddr;
    cts_pkg::t_slot            ram_wdata;
    logic [IW-1:0]             ram_raddr;
    logic [SW-1:0]             ram_rdata_raw;
    cts_pkg::t_slot            ram_rdata;

    logic                      issue_more;
    logic                      table_full;
    logic [cts_pkg::CNT_W-1:0] dec_count;
    logic [cts_pkg::CNT_W-1:0] new_count;

    // Slot table memory.
    cts_ram #(
        .WIDTH (SW),
        .DEPTH (SLOT_COUNT)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_waddr),
        .i_wr_data (SW'(ram_wdata)),
        .i_rd_addr (ram_raddr),
        .o_rd_data (ram_rdata_raw)
    );

    assign ram_rdata  = cts_pkg::t_slot'(ram_rdata_raw);
    assign issue_more = (r_issue < r_filled);
    assign table_full = (r_filled >= CW'(SLOT_COUNT));
    assign ram_raddr  = r_issue[IW-1:0];

    // Remaining decrements minus one until the slot being read expires.
    assign dec_count = ram_rdata.count - 8'd1;

    // New countdown in the update pass: the winner reloads, earlier slots
    // took one more decrement in the last pass than later ones.
    always_comb begin
        if (r_pend_idx == r_win) begin
            new_count = ram_rdata.period;
        end else if (r_pend_idx < r_win) begin
            new_count = ram_rdata.count - r_min - 8'd1;
        end else begin
            new_count = ram_rdata.count - r_min;
        end
    end

    // Sequencer next-state logic.
    always_comb begin
        n_state    = r_state;
        n_filled   = r_filled;
        n_issue    = r_issue;
        n_pend     = r_pend;
        n_pend_idx = r_pend_idx;
        n_min      = r_min;
        n_win      = r_win;
        n_win_id   = r_win_id;
        n_done     = 1'b0;
        n_slot     = r_slot;
        n_id       = r_id;
        n_no_task  = r_no_task;
        n_replaced = r_replaced;
        ram_we     = 1'b0;
        ram_waddr  = r_pend_idx;
        ram_wdata  = ram_rdata;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (!i_command) begin
                        // Add: fill the next slot, or the last one when full.
                        ram_we           = 1'b1;
                        ram_wdata.id     = i_new_task_id;
                        ram_wdata.period = i_reload_period;
                        ram_wdata.count  = i_reload_period;
                        if (table_full) begin
                            ram_waddr = IW'(SLOT_COUNT - 1);
                        end else begin
                            ram_waddr = r_filled[IW-1:0];
                            n_filled  = r_filled + CW'(1);
                        end
                        n_done     = 1'b1;
                        n_slot     = 5'(ram_waddr);
                        n_id       = i_new_task_id;
                        n_no_task  = 1'b0;
                        n_replaced = table_full;
                    end else if (r_filled == '0) begin
                        // Schedule on an empty table.
                        n_done     = 1'b1;
                        n_slot     = '0;
                        n_id       = '0;
                        n_no_task  = 1'b1;
                        n_replaced = 1'b0;
                    end else begin
                        n_state = S_SCAN;
                        n_issue = '0;
                        n_pend  = 1'b0;
                    end
                end
            end

            S_SCAN: begin
                // Issue the next read while evaluating the previous one.
                if (issue_more) begin
                    n_issue    = r_issue + CW'(1);
                    n_pend     = 1'b1;
                    n_pend_idx = r_issue[IW-1:0];
                end else begin
                    n_pend = 1'b0;
                end
                if (r_pend) begin
                    if (r_pend_idx == '0 || dec_count < r_min) begin
                        n_min    = dec_count;
                        n_win    = r_pend_idx;
                        n_win_id = ram_rdata.id;
                    end
                    if (!issue_more) begin
                        n_state = S_UPDATE;
                        n_issue = '0;
                        n_pend  = 1'b0;
                    end
                end
            end

            S_UPDATE: begin
                // Read-modify-write of each countdown, one slot a cycle.
                if (issue_more) begin
                    n_issue    = r_issue + CW'(1);
                    n_pend     = 1'b1;
                    n_pend_idx = r_issue[IW-1:0];
                end else begin
                    n_pend = 1'b0;
                end
                if (r_pend) begin
                    ram_we          = 1'b1;
                    ram_wdata.count = new_count;
                    if (!issue_more) begin
                        n_state    = S_IDLE;
                        n_done     = 1'b1;
                        n_slot     = 5'(r_win);
                        n_id       = r_win_id;
                        n_no_task  = 1'b0;
                        n_replaced = 1'b0;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_filled <= '0;
            r_issue  <= '0;
            r_pend   <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_filled <= n_filled;
            r_issue  <= n_issue;
            r_pend   <= n_pend;
            r_done   <= n_done;
        end
        r_pend_idx <= n_pend_idx;
        r_min      <= n_min;
        r_win      <= n_win;
        r_win_id   <= n_win_id;
        r_slot     <= n_slot;
        r_id       <= n_id;
        r_no_task  <= n_no_task;
        r_replaced <= n_replaced;
    end

    assign busy             = (r_state != S_IDLE);
    assign o_done           = r_done;
    assign o_chosen_slot    = r_slot;
    assign o_chosen_task_id = r_id;
    assign o_no_task        = r_no_task;
    assign o_replaced_last  = r_replaced;

endmodule

// ===== rtl/cts_checker.sv =====
// Port-level checker for the countdown task scheduler, bound to the top level.
`include "assert_macros.svh"

module cts_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       start,
    input logic                       busy,
    input logic                       i_command,
    input logic                       o_done,
    input logic [cts_pkg::SLOT_W-1:0] o_chosen_slot,
    input logic [cts_pkg::ID_W-1:0]   o_chosen_task_id,
    input logic                       o_no_task,
    input logic                       o_replaced_last
);

    logic in_accept;
    logic empty_fields_zero;

    // Input handshake and the field pattern of an empty-table result.
    assign in_accept         = start && !busy;
    assign empty_fields_zero = (o_chosen_slot == '0) && (o_chosen_task_id == '0) &&
                               !o_replaced_last;

    // An add transaction completes in the next cycle without the empty-table flag.
    `ASSERT_NEXT(a_add_done, i_clk, i_rst_n, in_accept && !i_command, o_done && !o_no_task)

    // A schedule transaction either starts a walk or reports an empty table.
    `ASSERT_NEXT(a_sched_go, i_clk, i_rst_n, in_accept && i_command, busy || o_done && o_no_task)

    // A result is only shown while the sequencer is back at rest.
    `ASSERT_SAME(a_done_idle, i_clk, i_rst_n, o_done, !busy)

    // An empty-table result carries no slot, no id and no replace flag.
    `ASSERT_SAME(a_empty_zero, i_clk, i_rst_n, o_done && o_no_task, empty_fields_zero)

endmodule

bind countdown_task_scheduler cts_checker u_cts_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .start            (start),
    .busy             (busy),
    .i_command        (i_command),
    .o_done           (o_done),
    .o_chosen_slot    (o_chosen_slot),
    .o_chosen_task_id (o_chosen_task_id),
    .o_no_task        (o_no_task),
    .o_replaced_last  (o_replaced_last)
);
